[rtl/lcfr_pkg.sv]
// Shared constants and types for the length and CRC framed receiver.
package lcfr_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int ADDR_W = $clog2(MAX_PAYLOAD);
  localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
  localparam int BYTE_W = 8;
  localparam int LEN_W = 8;
  localparam int CRC_W = 16;
  localparam int NUM_BANKS = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
  localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd126;
  localparam logic [LEN_W-1:0] CAPACITY_RESET = 8'd255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_BYTE = 1'd0,
    REG_ACCEPT_CAPACITY = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic bank;
    logic [LEN_W-1:0] len;
  } lcfr_desc_t;

  typedef struct packed {
    logic en;
    logic [ADDR_W:0] addr;
    logic [BYTE_W-1:0] data;
  } lcfr_wr_t;

endpackage

[rtl/lcfr_if.sv]
// Stream interfaces for received bytes and delivered payload bytes.
interface lcfr_in_if;
  logic valid;
  logic ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lcfr_out_if;
  logic valid;
  logic ready;
  logic [7:0] payload_byte;
  logic byte_present;
  logic [7:0] frame_length;
  logic last_of_frame;

  modport source (output valid, output payload_byte, output byte_present,
                  output frame_length, output last_of_frame, input ready);
  modport sink (input valid, input payload_byte, input byte_present,
                input frame_length, input last_of_frame, output ready);
endinterface

[rtl/lcfr_front.sv]
// Frame parser: start byte hunt, length, payload capture, CRC check.
module lcfr_front
  import lcfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  lcfr_in_if.sink in_stream,
  input  logic cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic occ_full,
  output lcfr_wr_t mem_wr,
  output logic push,
  output lcfr_desc_t push_desc
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CHECK0,
    PH_CHECK1
  } phase_t;

  function automatic logic [CRC_W-1:0] arc_update(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  phase_t phase;
  logic [LEN_W-1:0] exp_len;
  logic [POS_W-1:0] pos;
  logic [BYTE_W-1:0] crc_low;
  logic [CRC_W-1:0] crc;
  logic wbank;
  logic [BYTE_W-1:0] start_byte;
  logic [LEN_W-1:0] capacity;
  logic take;
  logic [LEN_W-1:0] pos_inc;

  assign in_stream.ready = !(occ_full && (phase == PH_PAYLOAD || phase == PH_CHECK1));
  assign take = in_stream.valid && in_stream.ready;
  assign pos_inc = LEN_W'(pos) + LEN_W'(1);

  assign mem_wr.en = take && (phase == PH_PAYLOAD);
  assign mem_wr.addr = {wbank, pos[ADDR_W-1:0]};
  assign mem_wr.data = in_stream.rx_byte;

  assign push = take && (phase == PH_CHECK1) && ({in_stream.rx_byte, crc_low} == crc) &&
                (exp_len <= capacity);
  assign push_desc = '{bank: wbank, len: exp_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      exp_len <= '0;
      pos <= '0;
      crc_low <= '0;
      crc <= '0;
      wbank <= 1'b0;
      start_byte <= START_BYTE_RESET;
      capacity <= CAPACITY_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_BYTE: start_byte <= cfg_data[BYTE_W-1:0];
          REG_ACCEPT_CAPACITY: capacity <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (push) begin
        wbank <= !wbank;
      end
      if (take) begin
        unique case (phase)
          PH_HUNT: begin
            if (in_stream.rx_byte == start_byte) begin
              phase <= PH_LENGTH;
            end
          end
          PH_LENGTH: begin
            pos <= '0;
            crc <= '0;
            if (in_stream.rx_byte > LEN_W'(MAX_PAYLOAD)) begin
              phase <= PH_HUNT;
              exp_len <= '0;
            end else begin
              exp_len <= in_stream.rx_byte;
              phase <= (in_stream.rx_byte == '0) ? PH_CHECK0 : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            crc <= arc_update(crc, in_stream.rx_byte);
            pos <= pos + POS_W'(1);
            if (pos_inc >= exp_len) begin
              phase <= PH_CHECK0;
            end
          end
          PH_CHECK0: begin
            crc_low <= in_stream.rx_byte;
            phase <= PH_CHECK1;
          end
          PH_CHECK1: begin
            phase <= PH_HUNT;
            exp_len <= '0;
            pos <= '0;
            crc_low <= '0;
            crc <= '0;
          end
          default: begin
            phase <= PH_HUNT;
            exp_len <= '0;
            pos <= '0;
            crc_low <= '0;
            crc <= '0;
          end
        endcase
      end
    end
  end

endmodule

[rtl/lcfr_desc_queue.sv]
// Two-entry queue of accepted frame descriptors between parser and drain.
module lcfr_desc_queue
  import lcfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  lcfr_desc_t push_desc,
  input  logic pop,
  output lcfr_desc_t head,
  output logic [1:0] count
);

  lcfr_desc_t entries [NUM_BANKS];
  logic wr_ptr;
  logic rd_ptr;

  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/lcfr_back.sv]
// Payload buffer and drain engine that delivers accepted frames byte by byte.
module lcfr_back
  import lcfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  lcfr_wr_t mem_wr,
  input  logic q_nonempty,
  input  lcfr_desc_t head,
  output logic pop,
  output logic busy,
  lcfr_out_if.source out_stream
);

  logic [BYTE_W-1:0] mem [NUM_BANKS * MAX_PAYLOAD];
  logic [BYTE_W-1:0] rdata;
  logic bank;
  logic [LEN_W-1:0] len;
  logic [POS_W-1:0] pos;
  logic rd_pending;
  logic pend_present;
  logic pend_last;
  logic [LEN_W-1:0] pend_len;
  logic issue;
  logic load;
  logic issue_last;

  assign pop = !busy && q_nonempty;
  assign load = rd_pending && (!out_stream.valid || out_stream.ready);
  assign issue = busy && (!rd_pending || load);
  assign issue_last = (len == '0) || ((LEN_W'(pos) + LEN_W'(1)) == len);

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
    if (issue) begin
      rdata <= mem[{bank, pos[ADDR_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rd_pending <= 1'b0;
      out_stream.valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        bank <= head.bank;
        len <= head.len;
        pos <= '0;
      end else if (issue) begin
        pos <= pos + POS_W'(1);
        if (issue_last) begin
          busy <= 1'b0;
        end
      end
      if (issue) begin
        rd_pending <= 1'b1;
        pend_present <= (len != '0);
        pend_last <= issue_last;
        pend_len <= len;
      end else if (load) begin
        rd_pending <= 1'b0;
      end
      if (load) begin
        out_stream.valid <= 1'b1;
        out_stream.payload_byte <= pend_present ? rdata : '0;
        out_stream.byte_present <= pend_present;
        out_stream.frame_length <= pend_len;
        out_stream.last_of_frame <= pend_last;
      end else if (out_stream.ready) begin
        out_stream.valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_write_to_drained_bank: assert property (@(posedge clk) disable iff (rst)
    mem_wr.en && busy |-> mem_wr.addr[ADDR_W] != bank)
    else $error("payload write hits the bank being drained");

  a_rdata_holds: assert property (@(posedge clk) disable iff (rst)
    rd_pending && !load |=> $stable(rdata))
    else $error("read data changed while waiting for the output register");

  a_empty_frame_result: assert property (@(posedge clk) disable iff (rst)
    out_stream.valid && !out_stream.byte_present |->
      out_stream.last_of_frame && out_stream.frame_length == '0)
    else $error("result without a byte is not a lone empty frame");

  a_position_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (LEN_W'(pos) < len) || (len == '0 && pos == '0))
    else $error("drain position ran past the frame length");
`endif

endmodule

[rtl/length_crc_frame_receiver_core.sv]
// Top level of the length-prefixed frame receiver with CRC-16/ARC check.
//
// in_stream carries received bytes, one per transfer. The parser hunts for
// the start byte, reads a length byte, up to 64 payload bytes and a 16-bit
// CRC sent low byte first. Frames with a matching CRC and a length no larger
// than accept_capacity are delivered on out_stream, one transfer per payload
// byte with the frame length and a last flag; an empty frame gives a single
// transfer with byte_present low. Bad frames are dropped without notice.
// The parser takes one byte per cycle. Payload is captured into a two-bank
// buffer, so a second frame can be received while the first is drained.
// The drain delivers one transfer per cycle; once its last CRC byte is taken,
// a frame passes through the descriptor queue and the read data register.
// With both banks held by undelivered frames, in_stream stalls on payload and
// final CRC bytes until a bank frees up; out_stream stalls hold the drain state.
// Reset clears parser, queue and drain state and restores start_byte to 126
// and accept_capacity to 255. Configuration writes take effect at once.
module length_crc_frame_receiver_core
  import lcfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  lcfr_in_if.sink in_stream,
  lcfr_out_if.source out_stream,
  input  logic cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lcfr_wr_t mem_wr;
  lcfr_desc_t push_desc;
  lcfr_desc_t head;
  logic push;
  logic pop;
  logic busy;
  logic [1:0] count;
  logic occ_full;

  assign occ_full = (count + 2'(busy)) >= 2'(NUM_BANKS);

  lcfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_stream (in_stream),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .occ_full  (occ_full),
    .mem_wr    (mem_wr),
    .push      (push),
    .push_desc (push_desc)
  );

  lcfr_desc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .count     (count)
  );

  lcfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mem_wr     (mem_wr),
    .q_nonempty (count != '0),
    .head       (head),
    .pop        (pop),
    .busy       (busy),
    .out_stream (out_stream)
  );

endmodule
